[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stack with search
// Concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LSS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define LSS_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define LSS_ASSERT(lbl, clk, rstn, prop)
`define LSS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[src/lss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack with search package
// Shared types and constants of the stack cells and the top level.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int SCAN_MAX  = 8;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic load_match;
        logic scan_shift;
    } t_cell_ctl;

endpackage

[src/lss_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack cell
// Holds one stack word, its valid flag and a search match bit.
// ----------------------------------------------------------------------------
module lss_cell
    import lss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_up_data,
    input  logic                      i_up_valid,
    input  logic signed [VALUE_W-1:0] i_down_data,
    input  logic                      i_down_valid,
    input  logic signed [VALUE_W-1:0] i_key,
    input  logic                      i_scan_in,
    output logic signed [VALUE_W-1:0] o_data,
    output logic                      o_valid,
    output logic                      o_match
);

    logic signed [VALUE_W-1:0] r_data;
    logic                      r_valid;
    logic                      r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.push) begin
                r_valid <= i_up_valid;
            end else if (i_ctl.pop) begin
                r_valid <= i_down_valid;
            end
            if (i_ctl.load_match) begin
                r_match <= r_valid && (r_data == i_key);
            end else if (i_ctl.scan_shift) begin
                r_match <= i_scan_in;
            end
        end
    end

    // Words need no reset: a word is only looked at while its cell is valid.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_up_data;
        end else if (i_ctl.pop) begin
            r_data <= i_down_data;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

[src/lifo_stack_with_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded LIFO stack with search
// A chain of cells holding signed words, top of stack in cell zero.
// ----------------------------------------------------------------------------
// Usage: drive i_opcode and i_value and raise start; the beat is taken at a
// rising edge where start is high and busy is low. Each beat gives exactly one
// result, shown for one cycle with o_done high; the receiver cannot stall it.
// Push, pop and peek need no scan: the result appears in the cycle after
// the accepting edge and busy stays low, so one of these operations can be
// issued every cycle. The cells shift towards the bottom on push and towards
// the top on pop.
// Search loads a match bit in every cell in parallel at the accepting edge.
// The match bits then shift up the chain SCAN_W cells per cycle while a small
// priority encoder looks at the top SCAN_W of them, so a search holds busy
// until a hit is seen or the window reaches the last filled cell (SCAN_W is
// 8, or DEPTH if smaller), and its result appears in the same cycle as busy
// falls. Searching an empty stack answers at once, like the other operations.
// Pop or peek on an empty stack reports underflow; push on a full stack is
// dropped with overflow. Reset empties the stack and clears the strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_with_search
    import lss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_done,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic [POS_W-1:0]          o_position,
    output logic [POS_W-1:0]          o_entry_count,
    output logic                      o_is_empty,
    output logic [1:0]                o_status
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SCAN_W = (DEPTH < SCAN_MAX) ? DEPTH : SCAN_MAX;
    localparam int IDX_W  = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;

    // Chain signals.
    t_cell_ctl                 cell_ctl;
    logic signed [VALUE_W-1:0] cell_data  [DEPTH];
    logic                      cell_valid [DEPTH];
    logic                      cell_match [DEPTH];

    // Control and result registers.
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_base,  n_base;
    logic                      r_done,  n_done;
    logic signed [VALUE_W-1:0] r_read,  n_read;
    logic [CNT_W-1:0]          r_pos,   n_pos;
    logic [CNT_W-1:0]          r_cnt_out, n_cnt_out;
    t_status                   r_status, n_status;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    logic                      scan_hit;
    logic [IDX_W-1:0]          scan_idx;
    logic                      scan_last;
    logic [CNT_W:0]            scan_end;
    logic [CNT_W:0]            hit_pos;
    logic [CNT_W+POS_W-1:0]    pos_ext;
    logic [CNT_W+POS_W-1:0]    cnt_ext;

    // ------------------------------------------------------------------
    // Cell chain: cell i holds the word i places below the top.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] up_data;
        logic                      up_valid;
        logic signed [VALUE_W-1:0] down_data;
        logic                      down_valid;
        logic                      scan_in;

        if (g == 0) begin : g_top
            assign up_data  = i_value;
            assign up_valid = 1'b1;
        end else begin : g_mid
            assign up_data  = cell_data[g-1];
            assign up_valid = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_bottom
            assign down_data  = '0;
            assign down_valid = 1'b0;
        end else begin : g_inner
            assign down_data  = cell_data[g+1];
            assign down_valid = cell_valid[g+1];
        end

        if (g + SCAN_W < DEPTH) begin : g_scan
            assign scan_in = cell_match[g+SCAN_W];
        end else begin : g_scan_end
            assign scan_in = 1'b0;
        end

        // The match bits are loaded at the accepting edge, so every cell
        // compares against the search word while it is still on the port.
        lss_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_up_data    (up_data),
            .i_up_valid   (up_valid),
            .i_down_data  (down_data),
            .i_down_valid (down_valid),
            .i_key        (i_value),
            .i_scan_in    (scan_in),
            .o_data       (cell_data[g]),
            .o_valid      (cell_valid[g]),
            .o_match      (cell_match[g])
        );
    end

    assign busy     = (r_state == S_SCAN);
    assign accept   = start && !busy;
    assign is_full  = cell_valid[DEPTH-1];
    assign is_empty = !cell_valid[0];

    // ------------------------------------------------------------------
    // Search window: the topmost set match bit among the first SCAN_W
    // cells is the nearest hit, since the bits above were already seen.
    // ------------------------------------------------------------------
    always_comb begin
        scan_hit = 1'b0;
        scan_idx = '0;
        for (int k = SCAN_W - 1; k >= 0; k--) begin
            if (cell_match[k]) begin
                scan_hit = 1'b1;
                scan_idx = IDX_W'(k);
            end
        end
        hit_pos   = {1'b0, r_base} + (CNT_W + 1)'(scan_idx) + (CNT_W + 1)'(1);
        scan_end  = {1'b0, r_base} + (CNT_W + 1)'(SCAN_W);
        scan_last = (scan_end >= {1'b0, r_count});
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, cell commands and the result beat.
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_base    = r_base;
        n_done    = 1'b0;
        n_read    = r_read;
        n_pos     = r_pos;
        n_cnt_out = r_cnt_out;
        n_status  = r_status;
        cell_ctl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_read   = '0;
                    n_pos    = '0;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    unique case (t_op'(i_opcode))
                        OP_PUSH: begin
                            if (is_full) begin
                                n_status = ST_OVER;
                            end else begin
                                cell_ctl.push = 1'b1;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                n_status = ST_UNDER;
                            end else begin
                                cell_ctl.pop = 1'b1;
                                n_read       = cell_data[0];
                                n_count      = r_count - CNT_W'(1);
                            end
                        end
                        OP_PEEK: begin
                            if (is_empty) begin
                                n_status = ST_UNDER;
                            end else begin
                                n_read = cell_data[0];
                            end
                        end
                        OP_SEARCH: begin
                            if (!is_empty) begin
                                // Result follows once the scan ends.
                                cell_ctl.load_match = 1'b1;
                                n_base  = '0;
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b0;
                        end
                    endcase
                    n_cnt_out = n_count;
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    n_done  = 1'b1;
                    n_pos   = scan_hit ? hit_pos[CNT_W-1:0] : '0;
                    n_state = S_IDLE;
                end else begin
                    cell_ctl.scan_shift = 1'b1;
                    n_base = scan_end[CNT_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_read    <= n_read;
        r_pos     <= n_pos;
        r_cnt_out <= n_cnt_out;
        r_status  <= n_status;
    end

    // Counts are reported in seven bits; deeper stacks wrap.
    assign pos_ext = {{POS_W{1'b0}}, r_pos};
    assign cnt_ext = {{POS_W{1'b0}}, r_cnt_out};

    assign o_done        = r_done;
    assign o_read_value  = r_read;
    assign o_position    = pos_ext[POS_W-1:0];
    assign o_entry_count = cnt_ext[POS_W-1:0];
    assign o_is_empty    = (r_cnt_out == '0);
    assign o_status      = r_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSS_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(DEPTH))
    `LSS_ASSERT(a_top_valid, i_clk, i_rst_n, cell_valid[0] == (r_count != '0))
    `LSS_ASSERT(a_bottom_valid, i_clk, i_rst_n, is_full == (r_count == CNT_W'(DEPTH)))
    `LSS_ASSERT(a_quick_result, i_clk, i_rst_n, (accept && i_opcode != OP_SEARCH) |=> o_done)
    `LSS_ASSERT(a_scan_nonempty, i_clk, i_rst_n, busy |-> (r_count != '0))

endmodule

[verif/lifo_stack_with_search_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bounded LIFO stack with search
// Drives push, pop, peek and search beats through the start/busy handshake,
// keeps its own copy of the stack to predict every result, and compares each
// strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_tb;
    import lss_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int RANDOM_CMDS = 950;

    // Commands in the stack_cmds queue are either real beats or a marker that
    // makes the driver hold off until every outstanding result has come back.
    typedef struct {
        bit                        drain_wait;
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_stack_cmd;

    typedef struct {
        logic signed [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          entry_count;
        logic                      is_empty;
        t_status                   status;
    } t_stack_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_opcode = OP_PUSH;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_done;
    logic signed [VALUE_W-1:0] o_read_value;
    logic [POS_W-1:0]          o_position;
    logic [POS_W-1:0]          o_entry_count;
    logic                      o_is_empty;
    logic [1:0]                o_status;

    t_stack_cmd    stack_cmds[$];
    t_stack_result due_results[$];

    // The testbench's own image of the stack: word zero is the bottom.
    logic signed [VALUE_W-1:0] model_words[STACK_DEPTH];
    int                        model_fill = 0;

    int beats_taken = 0;
    int results_seen = 0;
    int n_errors = 0;
    int n_push = 0, n_pop = 0, n_peek = 0, n_search = 0;
    int n_under = 0, n_over = 0, n_hits = 0, n_full = 0;

    // Fill level assumed by the stimulus generator, used only to shape phases.
    int                        gen_fill = 0;
    logic signed [VALUE_W-1:0] value_pool[8];

    lifo_stack_with_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_read_value  (o_read_value),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one accepted beat to the stack image and returns what the block
    // should report for it. Underflow and overflow leave the image untouched.
    function automatic t_stack_result apply_stack_op(t_op op, logic signed [VALUE_W-1:0] val);
        t_stack_result r;
        bit            found;
        r.read_value = '0;
        r.position   = '0;
        r.status     = ST_OK;
        found        = 1'b0;
        case (op)
            OP_PUSH: begin
                n_push++;
                if (model_fill == STACK_DEPTH) begin
                    r.status = ST_OVER;
                    n_over++;
                end else begin
                    model_words[model_fill] = val;
                    model_fill++;
                    if (model_fill == STACK_DEPTH) n_full++;
                end
            end
            OP_POP: begin
                n_pop++;
                if (model_fill == 0) begin
                    r.status = ST_UNDER;
                    n_under++;
                end else begin
                    model_fill--;
                    r.read_value = model_words[model_fill];
                end
            end
            OP_PEEK: begin
                n_peek++;
                if (model_fill == 0) begin
                    r.status = ST_UNDER;
                    n_under++;
                end else begin
                    r.read_value = model_words[model_fill - 1];
                end
            end
            default: begin
                // The scan starts at the top, so a duplicated word is found
                // at its uppermost copy.
                n_search++;
                for (int k = 0; k < model_fill; k++) begin
                    if (!found && model_words[model_fill - 1 - k] == val) begin
                        r.position = POS_W'(k + 1);
                        found = 1'b1;
                    end
                end
                if (found) n_hits++;
            end
        endcase
        r.entry_count = POS_W'(model_fill);
        r.is_empty    = (model_fill == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. gen_fill follows the expected fill level so that the
    // phases below can aim at a full or an empty stack on purpose.
    // ------------------------------------------------------------------------
    task automatic add_cmd(t_op op, logic signed [VALUE_W-1:0] val);
        t_stack_cmd c;
        c.drain_wait = 1'b0;
        c.op         = op;
        c.value      = val;
        stack_cmds.push_back(c);
        if (op == OP_PUSH && gen_fill < STACK_DEPTH) gen_fill++;
        if (op == OP_POP && gen_fill > 0) gen_fill--;
    endtask

    task automatic add_drain_wait();
        t_stack_cmd c;
        c.drain_wait = 1'b1;
        c.op         = OP_PUSH;
        c.value      = '0;
        stack_cmds.push_back(c);
    endtask

    // Half of the words come from a small pool so that searches hit and the
    // stack holds duplicates; the rest are fully random.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(1) == 0) return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic t_op pick_op(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct) return OP_PUSH;
        if (roll < push_pct + pop_pct) return OP_POP;
        if ($urandom_range(1) == 0) return OP_PEEK;
        return OP_SEARCH;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A beat is taken at an edge where start is high and busy is low;
    // the prediction is made there, from the values that were on the ports.
    // start and the payload receive at most one assignment per edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stack_cmd c;
        bit         next_start;
        bit         no_idle;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_opcode <= OP_PUSH;
            i_value  <= '0;
        end else begin
            if (start && !busy) begin
                due_results.push_back(apply_stack_op(t_op'(i_opcode), i_value));
                beats_taken++;
            end
            // While a beat is held off by busy, start and the payload stay put.
            if (!(start && busy)) begin
                next_start = 1'b0;
                // A long stretch in the middle of the run has no sender gaps.
                no_idle = (beats_taken >= 400 && beats_taken < 560);
                if (stack_cmds.size() > 0) begin
                    if (stack_cmds[0].drain_wait) begin
                        if (beats_taken == results_seen) void'(stack_cmds.pop_front());
                    end else if (no_idle || $urandom_range(99) >= 25) begin
                        c = stack_cmds.pop_front();
                        next_start = 1'b1;
                        i_opcode <= c.op;
                        i_value  <= c.value;
                    end
                end
                start <= next_start;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every strobed result is matched against the oldest prediction.
    // results_seen is updated nonblocking so that the driver always sees the
    // count as it stood before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stack_result e;
        if (i_rst_n && o_done) begin
            results_seen <= results_seen + 1;
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing expected: read_value %0d status %0d",
                         $time, o_read_value, o_status);
                n_errors++;
            end else begin
                e = due_results.pop_front();
                if (o_read_value !== e.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, e.read_value, o_read_value);
                    n_errors++;
                end
                if (o_position !== e.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, e.position, o_position);
                    n_errors++;
                end
                if (o_entry_count !== e.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, e.entry_count, o_entry_count);
                    n_errors++;
                end
                if (o_is_empty !== e.is_empty) begin
                    $display("%0t: is_empty expected %0b actual %0b",
                             $time, e.is_empty, o_is_empty);
                    n_errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int queued;
        int phase_len;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

        // Directed opening: every operation on an empty stack, the extreme
        // words, a duplicated word, a search miss and a drain past the bottom.
        add_cmd(OP_SEARCH, 32'sh0000_0000);
        add_cmd(OP_POP, 32'sh7fff_ffff);
        add_cmd(OP_PEEK, 32'sh8000_0000);
        add_cmd(OP_PUSH, 32'sh8000_0000);
        add_cmd(OP_PUSH, 32'sh7fff_ffff);
        add_cmd(OP_PUSH, 32'sh0000_0000);
        add_cmd(OP_PUSH, -1);
        add_cmd(OP_PUSH, 32'sh7fff_ffff);
        add_cmd(OP_PEEK, '0);
        add_cmd(OP_SEARCH, 32'sh7fff_ffff);
        add_cmd(OP_SEARCH, 32'sh8000_0000);
        add_cmd(OP_SEARCH, 32'sh0000_0000);
        add_cmd(OP_SEARCH, 32'sh0000_3039);
        add_cmd(OP_POP, '0);
        add_cmd(OP_SEARCH, 32'sh7fff_ffff);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_PEEK, '0);
        add_cmd(OP_SEARCH, -1);
        add_drain_wait();

        // Random phases: runs to a full stack with overflowing pushes, runs
        // down past empty, and mixed traffic, with the odd pause for drain.
        queued = 0;
        while (queued < RANDOM_CMDS) begin
            case ($urandom_range(3))
                0: begin
                    while (gen_fill < STACK_DEPTH) begin
                        if ($urandom_range(99) < 30) add_cmd(OP_SEARCH, pick_value());
                        else add_cmd(OP_PUSH, pick_value());
                        queued++;
                    end
                    phase_len = $urandom_range(3, 1);
                    repeat (phase_len) begin
                        add_cmd(OP_PUSH, pick_value());
                        add_cmd(OP_SEARCH, pick_value());
                        queued += 2;
                    end
                end
                1: begin
                    while (gen_fill > 0) begin
                        add_cmd(pick_op(0, 75), pick_value());
                        queued++;
                    end
                    phase_len = $urandom_range(3, 1);
                    repeat (phase_len) begin
                        add_cmd(pick_op(0, 50), pick_value());
                        queued++;
                    end
                end
                2: begin
                    phase_len = $urandom_range(60, 20);
                    repeat (phase_len) begin
                        add_cmd(pick_op(25, 25), pick_value());
                        queued++;
                    end
                end
                default: begin
                    phase_len = $urandom_range(60, 20);
                    repeat (phase_len) begin
                        add_cmd(pick_op(55, 15), pick_value());
                        queued++;
                    end
                end
            endcase
            if ($urandom_range(3) == 0) add_drain_wait();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last beat to be taken and its result to come back,
        // then keep the clock running to catch any stray strobe.
        while (stack_cmds.size() != 0 || start || beats_taken != results_seen)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (due_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
            n_errors++;
        end
        $display("Covered %0d beats: %0d push, %0d pop, %0d peek, %0d search.",
                 beats_taken, n_push, n_pop, n_peek, n_search);
        $display("Stack filled %0d times; %0d underflows, %0d overflows, %0d search hits.",
                 n_full, n_under, n_over, n_hits);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest legal run needs.
    initial begin
        #3_000_000;
        $display("%0t: run timed out", $time);
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lss_pkg.sv
src/lss_cell.sv
src/lifo_stack_with_search.sv
verif/lifo_stack_with_search_tb.sv
